// ----- hdl/sss_pkg.sv -----
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants for the sonar sweep speed sequencer.
// ----------------------------------------------------------------------------
package sss_pkg;

    // field widths
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned INCH_W   = 8;
    localparam int unsigned SWEEP_W  = 7;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned POWER_W  = 7;
    localparam int unsigned CODE_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // event kinds
    localparam logic KIND_ECHO  = 1'b0;
    localparam logic KIND_TIMER = 1'b1;

    // motor actions
    localparam logic [CODE_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] ACT_STOP  = 2'd1;
    localparam logic [CODE_W-1:0] ACT_DRIVE = 2'd2;

    // lamp codes
    localparam logic [CODE_W-1:0] LAMP_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] LAMP_GREEN = 2'd1;
    localparam logic [CODE_W-1:0] LAMP_RED   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRIG_WAIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_LEN    = 2'd3;

    // register reset values
    localparam logic [TICK_W-1:0]  ECHO_TIMEOUT_RST = 16'd30000;
    localparam logic [TICK_W-1:0]  RETRIG_WAIT_RST  = 16'd36666;
    localparam logic [INCH_W-1:0]  FAR_LIMIT_RST    = 8'd24;
    localparam logic [SWEEP_W-1:0] SWEEP_LEN_RST    = 7'd120;

    // distance and power arithmetic
    localparam int unsigned TICKS_PER_INCH = 148;
    localparam int unsigned POWER_BASE     = 101;
    localparam int unsigned POWER_NUM      = 11;
    localparam int unsigned POWER_DEN      = 720;
    localparam int unsigned THR_W          = 17;
    localparam int unsigned SCALED_W       = 20;
    // ticks*11 at or above this gives a quotient of 101 or more
    localparam int unsigned POWER_LIMIT    = POWER_BASE * POWER_DEN;
    // divide by 720 as shift by 4, then multiply by reciprocal of 45
    localparam int unsigned DIV_SHIFT      = 4;
    localparam int unsigned RECIP_45       = 93207;
    localparam int unsigned RECIP_SHIFT    = 22;
    localparam int unsigned RECIP_W        = 17;
    localparam int unsigned PART_W         = 13;
    localparam int unsigned PROD_W         = PART_W + RECIP_W;
    localparam logic [THR_W-1:0] FAR_THR_RST =
        THR_W'((FAR_LIMIT_RST + 1) * TICKS_PER_INCH);

endpackage

// ----- hdl/sss_if.sv -----
// ----------------------------------------------------------------------------
// sss_if
// Handshake channels of the sonar sweep speed sequencer.
// ----------------------------------------------------------------------------

// event channel: echo edges and timer matches
interface sss_event_if
    import sss_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [TICK_W-1:0] pulse_ticks;

    modport source (output valid, kind, pulse_ticks, input ready);
    modport sink   (input valid, kind, pulse_ticks, output ready);
endinterface

// result channel: timer, trigger, motor and lamp commands
interface sss_result_if
    import sss_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TICK_W-1:0]  timer_load;
    logic               trigger_pulse;
    logic [CODE_W-1:0]  motor_action;
    logic [POWER_W-1:0] motor_power;
    logic               motor_right;
    logic [CODE_W-1:0]  lamp;
    logic               done_res;

    modport source (output valid, timer_load, trigger_pulse, motor_action,
                    motor_power, motor_right, lamp, done_res, input ready);
    modport sink   (input valid, timer_load, trigger_pulse, motor_action,
                    motor_power, motor_right, lamp, done_res, output ready);
endinterface

// register write channel
interface sss_cfg_if
    import sss_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/sonar_sweep_speed_sequencer.sv -----
// ----------------------------------------------------------------------------
// sonar_sweep_speed_sequencer
// Ultrasonic ranger sequencer and motor speed controller. Each event word
// (echo edge or timer match) yields exactly one result word with the timer
// compare value to load, trigger request, motor command, lamp and done flag.
// The block takes one event word per clock while the result register is empty
// or being read. A word passes through the input register (where ticks*11
// is formed), then through the decision logic and the single 13x17
// reciprocal multiply into the result register. The result register frees
// itself as it is read, so a new word is taken while a finished one still
// waits. Register writes are taken at any time and apply to words that
// reach the decision stage afterwards.
// ----------------------------------------------------------------------------
module sonar_sweep_speed_sequencer
    import sss_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sss_event_if.sink     events,
    sss_result_if.source  results,
    sss_cfg_if.sink       cfg
);

    // configuration registers
    logic [TICK_W-1:0]  echo_timeout_reg;
    logic [TICK_W-1:0]  retrig_wait_reg;
    logic [THR_W-1:0]   far_thr_reg;
    logic [SWEEP_W-1:0] sweep_len_reg;

    // sequencer state
    logic               pending_reg, pending_next;
    logic               armed_reg, armed_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               right_reg, right_next;
    logic               finished_reg, finished_next;

    // input register
    logic                s1_valid_reg;
    logic                s1_kind_reg;
    logic [TICK_W-1:0]   s1_ticks_reg;
    logic [SCALED_W-1:0] s1_scaled_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [TICK_W-1:0]  load_reg, load_next;
    logic               trig_reg, trig_next;
    logic [CODE_W-1:0]  action_reg, action_next;
    logic [POWER_W-1:0] power_reg, power_next;
    logic [CODE_W-1:0]  lamp_reg, lamp_next;

    logic s1_take;
    logic s2_take;

    // datapath
    logic               beyond_far;
    logic               near_range;
    logic [TICK_W-1:0]  scaled_div16;
    logic [PROD_W-1:0]  quot_prod;
    logic [POWER_W-1:0] quot;
    logic [POWER_W-1:0] drive_power;
    logic               pend_mid;
    logic               armed_mid;
    logic [COUNT_W-1:0] count_mid;
    logic [COUNT_W-1:0] count_sat;

    // handshakes
    assign s2_take      = s1_valid_reg && (!out_valid_reg || results.ready);
    assign events.ready = !s1_valid_reg || s2_take;
    assign s1_take      = events.valid && events.ready;
    assign cfg.ready    = 1'b1;

    // register writes; far limit kept as a tick threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_timeout_reg <= ECHO_TIMEOUT_RST;
            retrig_wait_reg  <= RETRIG_WAIT_RST;
            far_thr_reg      <= FAR_THR_RST;
            sweep_len_reg    <= SWEEP_LEN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ECHO_TIMEOUT: echo_timeout_reg <= cfg.data;
                CFG_RETRIG_WAIT:  retrig_wait_reg  <= cfg.data;
                CFG_FAR_LIMIT:    far_thr_reg <=
                    THR_W'((THR_W'(cfg.data[INCH_W-1:0]) + THR_W'(1))
                           * THR_W'(TICKS_PER_INCH));
                CFG_SWEEP_LEN:    sweep_len_reg <= cfg.data[SWEEP_W-1:0];
                default:          echo_timeout_reg <= echo_timeout_reg;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (events.ready)
            s1_valid_reg <= events.valid;
    end

    // input register payload with ticks*11
    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_kind_reg   <= events.kind;
            s1_ticks_reg  <= events.pulse_ticks;
            s1_scaled_reg <= SCALED_W'(events.pulse_ticks) * SCALED_W'(POWER_NUM);
        end
    end

    // distance test: ticks/148 > limit  <=>  ticks >= (limit+1)*148
    assign beyond_far = THR_W'(s1_ticks_reg) >= far_thr_reg;

    // power: 101 - ticks*11/720, zero once the quotient reaches 101
    assign near_range   = s1_scaled_reg < SCALED_W'(POWER_LIMIT);
    assign scaled_div16 = s1_scaled_reg[SCALED_W-1:DIV_SHIFT];
    assign quot_prod    = PROD_W'(scaled_div16[PART_W-1:0]) * PROD_W'(RECIP_45);
    assign quot         = quot_prod[RECIP_SHIFT+POWER_W-1:RECIP_SHIFT];
    assign drive_power  = near_range ? (POWER_W'(POWER_BASE) - quot) : '0;

    // saturating measurement count
    assign count_sat = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);

    // sequencer decision
    always_comb
    begin
        pending_next  = pending_reg;
        armed_next    = armed_reg;
        count_next    = count_reg;
        right_next    = right_reg;
        finished_next = finished_reg;
        load_next     = '0;
        trig_next     = 1'b0;
        action_next   = ACT_NONE;
        power_next    = '0;
        lamp_next     = LAMP_NONE;
        pend_mid      = pending_reg;
        armed_mid     = armed_reg;
        count_mid     = count_reg;

        if (s1_kind_reg == KIND_ECHO)
        begin
            if (!pending_reg)
            begin
                pending_next = 1'b1;
                load_next    = echo_timeout_reg;
            end
            else
            begin
                if (beyond_far)
                begin
                    action_next = ACT_STOP;
                    lamp_next   = LAMP_GREEN;
                end
                else
                begin
                    action_next = ACT_DRIVE;
                    power_next  = drive_power;
                    lamp_next   = LAMP_RED;
                end
                count_next   = count_sat;
                pending_next = 1'b0;
                armed_next   = 1'b0;
            end
        end
        else
        begin
            // timeout while an echo is outstanding
            if (pending_reg)
            begin
                lamp_next   = LAMP_GREEN;
                action_next = ACT_STOP;
                count_mid   = count_sat;
                pend_mid    = 1'b0;
                armed_mid   = 1'b0;
            end
            pending_next = pend_mid;
            count_next   = count_mid;
            armed_next   = armed_mid;

            // retrigger wait, then trigger along the sweep
            priority if (!armed_mid)
            begin
                load_next  = retrig_wait_reg;
                armed_next = 1'b1;
            end
            else if (count_mid < COUNT_W'(sweep_len_reg))
            begin
                right_next = 1'b1;
                trig_next  = 1'b1;
            end
            else if (count_mid < {sweep_len_reg, 1'b0})
            begin
                right_next = 1'b0;
                trig_next  = 1'b1;
            end
            else
            begin
                finished_next = 1'b1;
            end
        end
    end

    // result valid
    always_comb
    begin
        priority if (s2_take)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state and result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            count_reg     <= '0;
            right_reg     <= 1'b0;
            finished_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s2_take)
            begin
                pending_reg  <= pending_next;
                armed_reg    <= armed_next;
                count_reg    <= count_next;
                right_reg    <= right_next;
                finished_reg <= finished_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s2_take)
        begin
            load_reg   <= load_next;
            trig_reg   <= trig_next;
            action_reg <= action_next;
            power_reg  <= power_next;
            lamp_reg   <= lamp_next;
        end
    end

    // result word; direction and done follow the committed state
    assign results.valid         = out_valid_reg;
    assign results.timer_load    = load_reg;
    assign results.trigger_pulse = trig_reg;
    assign results.motor_action  = action_reg;
    assign results.motor_power   = power_reg;
    assign results.motor_right   = right_reg;
    assign results.lamp          = lamp_reg;
    assign results.done_res      = finished_reg;

`ifndef SYNTH
    // done never clears once set
    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("finished flag cleared");

    // power only accompanies a drive command
    a_power_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && action_reg != ACT_DRIVE) |-> power_reg == '0)
        else $error("motor power without drive");

    // a trigger word never also restarts the timer
    a_trig_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && trig_reg) |-> load_reg == '0)
        else $error("trigger with timer load");

    // stop shows green, drive shows red
    a_lamp_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((action_reg == ACT_STOP && lamp_reg == LAMP_GREEN)
                        || (action_reg == ACT_DRIVE && lamp_reg == LAMP_RED)
                        || (action_reg == ACT_NONE && lamp_reg == LAMP_NONE)))
        else $error("lamp does not match motor action");
`endif

endmodule
